// ----- src/pli_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pli_pkg
// Types and constants shared by the positional list core and its cells.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = 7;
	localparam int GRP    = 8;
	localparam int GRP_W  = $clog2(GRP);
	localparam int NGRP   = DEPTH / GRP;
	localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_LOCATE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] op;
		logic [6:0] position;
		logic [7:0] item_value;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] read_value;
		logic [6:0] found_at;
		logic [6:0] count;
		logic       is_empty;
	} rsp_t;

	// broadcast to every cell in the cycle a request is taken
	typedef struct packed {
		logic             fire;
		logic [1:0]       op;
		logic             ok;
		logic [CNT_W-1:0] pos_m1;
		logic [7:0]       item_value;
		logic [CNT_W-1:0] fill;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- src/pli_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pli_req_if
// Request channel: valid/ready handshake with operation, position and byte.
// ----------------------------------------------------------------------------
interface pli_req_if
	import pli_pkg::*;
;
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/pli_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pli_rsp_if
// Response channel: valid/ready handshake with status, data and list length.
// ----------------------------------------------------------------------------
interface pli_rsp_if
	import pli_pkg::*;
;
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/positional_list_insert_delete_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core
// Ordered byte list in a chain of slot cells, addressed by 1-based position.
// ----------------------------------------------------------------------------
// The cells shift and register their taps when the request is taken, and
// the reduction of those taps fills the output register when the stage
// advances, which output backpressure can hold off.
// Throughput: one request per cycle, limited only by output backpressure.
// Reset: arst_n clears the element count and the handshake state; slot
// contents stay unknown until written and are never read before that.
module positional_list_insert_delete_core
	import pli_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	pli_req_if.sink    req,
	pli_rsp_if.source  rsp
);

	logic             accept;
	logic             advance;
	logic             valid_s1;
	logic [1:0]       op_s1;
	logic             ok_s1;
	logic [CNT_W-1:0] fill_s1;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_next;
	logic             req_ok;
	logic [CNT_W:0]   pos_w;
	logic [CNT_W:0]   fill_w;
	cell_ctrl_t       ctrl;
	logic [7:0]       cell_data [DEPTH];
	logic [7:0]       cell_sel  [DEPTH];
	logic [DEPTH-1:0] cell_hit;
	logic [CNT_W-1:0] red_found;
	logic [7:0]       red_value;
	logic             out_valid_q;
	rsp_t             out_q;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	assign pos_w  = {1'b0, req.data.position};
	assign fill_w = {1'b0, fill_q};

	always_comb begin
		req_ok    = 1'b0;
		fill_next = fill_q;
		case (req.data.op)
			OP_INSERT: begin
				req_ok = (pos_w != '0) && (pos_w <= fill_w + (CNT_W+1)'(1))
					&& (fill_w < (CNT_W+1)'(DEPTH));
				if (req_ok) begin
					fill_next = fill_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				req_ok = (pos_w != '0) && (pos_w <= fill_w);
				if (req_ok) begin
					fill_next = fill_q - CNT_W'(1);
				end
			end
			OP_GET: begin
				req_ok = (pos_w != '0) && (pos_w <= fill_w);
			end
			default: begin
				req_ok = 1'b1;
			end
		endcase
	end

	assign ctrl.fire       = accept;
	assign ctrl.op         = req.data.op;
	assign ctrl.ok         = req_ok;
	assign ctrl.pos_m1     = req.data.position - CNT_W'(1);
	assign ctrl.item_value = req.data.item_value;
	assign ctrl.fill       = fill_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [7:0] lower;
		logic [7:0] upper;

		if (i == 0) begin : g_first
			assign lower = 8'h00;
		end else begin : g_lower
			assign lower = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper = 8'h00;
		end else begin : g_upper
			assign upper = cell_data[i+1];
		end

		pli_cell u_cell (
			.clk    (clk),
			.idx    (IDX_W'(i)),
			.ctrl   (ctrl),
			.lower  (lower),
			.upper  (upper),
			.data_q (cell_data[i]),
			.hit_s1 (cell_hit[i]),
			.sel_s1 (cell_sel[i])
		);
	end

	pli_reduce u_reduce (
		.hit        (cell_hit),
		.sel        (cell_sel),
		.found_at   (red_found),
		.read_value (red_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_next;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= req.data.op;
			ok_s1   <= req_ok;
			fill_s1 <= fill_next;
		end
	end

	// drop taps that do not belong to the operation
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.ok         <= ok_s1;
			out_q.read_value <= (ok_s1 && (op_s1 == OP_DELETE || op_s1 == OP_GET))
				? red_value : 8'h00;
			out_q.found_at   <= (op_s1 == OP_LOCATE) ? red_found : '0;
			out_q.count      <= fill_s1;
			out_q.is_empty   <= (fill_s1 == '0);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule
`default_nettype wire

// ----- src/pli_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pli_cell
// One list slot. Shifts up or down with its neighbors on insert and delete,
// and registers its match flag and read tap for the reduction stage.
// ----------------------------------------------------------------------------
module pli_cell
	import pli_pkg::*;
(
	input  wire logic             clk,
	input  wire logic [IDX_W-1:0] idx,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [7:0]       lower,
	input  wire logic [7:0]       upper,
	output logic      [7:0]       data_q,
	output logic                  hit_s1,
	output logic      [7:0]       sel_s1
);

	logic [CNT_W-1:0] my_pos;

	assign my_pos = CNT_W'(idx);

	always_ff @(posedge clk) begin
		if (ctrl.fire && ctrl.ok) begin
			case (ctrl.op)
				OP_INSERT: begin
					if (my_pos > ctrl.pos_m1) begin
						data_q <= lower;
					end else if (my_pos == ctrl.pos_m1) begin
						data_q <= ctrl.item_value;
					end
				end
				OP_DELETE: begin
					if (my_pos >= ctrl.pos_m1) begin
						data_q <= upper;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// sample the contents as they stood before this request
	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			hit_s1 <= (data_q == ctrl.item_value) && (my_pos < ctrl.fill);
			sel_s1 <= (my_pos == ctrl.pos_m1) ? data_q : 8'h00;
		end
	end

endmodule
`default_nettype wire

// ----- src/pli_reduce.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pli_reduce
// Combines the per-cell taps: first matching position in two levels of
// eight, and the OR of the selected read bytes.
// ----------------------------------------------------------------------------
module pli_reduce
	import pli_pkg::*;
(
	input  wire logic [DEPTH-1:0] hit,
	input  wire logic [7:0]       sel [DEPTH],
	output logic      [CNT_W-1:0] found_at,
	output logic      [7:0]       read_value
);

	logic [NGRP-1:0]  grp_any;
	logic [GRP_W-1:0] grp_lo [NGRP];
	logic [IDX_W-1:0] first_pos;
	logic             any_hit;

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any[g] = |hit[g*GRP +: GRP];
			grp_lo[g]  = '0;
			for (int k = GRP - 1; k >= 0; k--) begin
				if (hit[g*GRP + k]) begin
					grp_lo[g] = GRP_W'(k);
				end
			end
		end
	end

	always_comb begin
		any_hit   = |grp_any;
		first_pos = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any[g]) begin
				first_pos = IDX_W'(g * GRP) | IDX_W'(grp_lo[g]);
			end
		end
		found_at = any_hit ? (CNT_W'(first_pos) + CNT_W'(1)) : '0;
	end

	always_comb begin
		read_value = 8'h00;
		for (int i = 0; i < DEPTH; i++) begin
			read_value = read_value | sel[i];
		end
	end

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional list core: a directed opening, then
// random grow, shrink and mixed phases. Every request is run through an
// in-bench list model and the responses are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;
	import pli_pkg::*;

	localparam int N_RANDOM  = 1800;
	localparam int QUIET_TAIL = 150;
	localparam int STALL_LIMIT = 1000;

	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

	typedef struct {
		req_t r;
		bit   hold;
	} stim_t;

	logic clk;
	logic arst_n;

	pli_req_if req_ch ();
	pli_rsp_if rsp_ch ();

	positional_list_insert_delete_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	stim_t pending[$];
	rsp_t  expected_rsp[$];

	// list model
	logic [7:0] list_mem [DEPTH];
	int         list_len;

	int gen_fill;
	int n_stim;
	int sent_cnt;
	int checked_cnt;
	int mismatches;
	int op_seen [4];
	int rejects;
	int full_rejects;
	int locate_hits;
	int deepest;
	int send_gap;
	int stall_left;
	int idle_cycles;
	logic quiet;

	assign quiet = (n_stim > 0) && (sent_cnt + QUIET_TAIL >= n_stim);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic rsp_t list_apply(req_t r);
		rsp_t o;
		int p;
		o = '0;
		p = int'(r.position);
		op_seen[r.op]++;
		case (op_t'(r.op))
			OP_INSERT: begin
				if (p >= 1 && p <= list_len + 1 && list_len < DEPTH) begin
					for (int j = list_len; j > p - 1; j--)
						list_mem[j] = list_mem[j-1];
					list_mem[p-1] = r.item_value;
					list_len++;
					o.ok = 1'b1;
				end else begin
					rejects++;
					if (list_len == DEPTH)
						full_rejects++;
				end
			end
			OP_DELETE: begin
				if (p >= 1 && p <= list_len) begin
					o.read_value = list_mem[p-1];
					for (int j = p - 1; j + 1 < list_len; j++)
						list_mem[j] = list_mem[j+1];
					list_len--;
					o.ok = 1'b1;
				end else begin
					rejects++;
				end
			end
			OP_GET: begin
				if (p >= 1 && p <= list_len) begin
					o.read_value = list_mem[p-1];
					o.ok = 1'b1;
				end else begin
					rejects++;
				end
			end
			default: begin
				o.ok = 1'b1;
				for (int j = 0; j < list_len; j++) begin
					if (o.found_at == 0 && list_mem[j] == r.item_value)
						o.found_at = CNT_W'(j + 1);
				end
				if (o.found_at != 0)
					locate_hits++;
			end
		endcase
		o.count = CNT_W'(list_len);
		o.is_empty = (list_len == 0);
		if (list_len > deepest)
			deepest = list_len;
		return o;
	endfunction

	// track the length at generation time so most positions land in range
	task automatic queue_request(op_t op, int pos, int val, bit hold);
		stim_t s;
		s.r.op = op;
		s.r.position = pos[6:0];
		s.r.item_value = val[7:0];
		s.hold = hold;
		pending.push_back(s);
		if (op == OP_INSERT && pos >= 1 && pos <= gen_fill + 1 && gen_fill < DEPTH)
			gen_fill++;
		else if (op == OP_DELETE && pos >= 1 && pos <= gen_fill)
			gen_fill--;
	endtask

	function automatic int pick_position(op_t op, int fill);
		int top;
		top = (op == OP_INSERT) ? fill + 1 : fill;
		if (op == OP_LOCATE)
			return $urandom_range(0, 127);
		if ($urandom_range(0, 9) < 8 && top >= 1 && top <= DEPTH) begin
			case ($urandom_range(0, 3))
				0: return 1;
				1: return top;
				default: return $urandom_range(1, top);
			endcase
		end
		case ($urandom_range(0, 2))
			0: return 0;
			1: return $urandom_range(top + 1, 127);
			default: return $urandom_range(0, 127);
		endcase
	endfunction

	function automatic int pick_value();
		case ($urandom_range(0, 5))
			0, 1: return $urandom_range(0, 7);
			2: return $urandom_range(0, 1) ? 8'hFF : 8'h80;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_response(rsp_t got);
		rsp_t want;
		if (expected_rsp.size() == 0) begin
			$display("%0t: response with none outstanding, expected nothing, got %h",
				$time, got);
			mismatches++;
		end else begin
			want = expected_rsp.pop_front();
			checked_cnt++;
			compare_field("ok", 8'(want.ok), 8'(got.ok));
			compare_field("read_value", want.read_value, got.read_value);
			compare_field("found_at", 8'(want.found_at), 8'(got.found_at));
			compare_field("count", 8'(want.count), 8'(got.count));
			compare_field("is_empty", 8'(want.is_empty), 8'(got.is_empty));
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_req
		stim_t s;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			send_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_rsp.push_back(list_apply(req_ch.data));
				sent_cnt++;
				if (!quiet && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 5);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending.size() > 0 &&
						!(pending[0].hold && expected_rsp.size() > 0)) begin
					s = pending.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.data <= s.r;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor with random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_response(rsp_ch.data);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		mix_t mix;
		int len;
		int phase;
		int rand_cnt;
		int w;
		op_t op;

		// empty-list corners, then a short list with duplicates
		queue_request(OP_GET, 1, 8'h00, 1'b0);
		queue_request(OP_DELETE, 1, 8'h00, 1'b0);
		queue_request(OP_LOCATE, 0, 8'h00, 1'b0);
		queue_request(OP_INSERT, 0, 8'h11, 1'b0);
		queue_request(OP_INSERT, 2, 8'h22, 1'b0);
		queue_request(OP_INSERT, 1, 8'hFF, 1'b0);
		queue_request(OP_INSERT, 1, 8'h00, 1'b0);
		queue_request(OP_INSERT, 3, 8'h80, 1'b0);
		queue_request(OP_INSERT, 2, 8'h7F, 1'b0);
		queue_request(OP_INSERT, 127, 8'h01, 1'b0);
		queue_request(OP_GET, 0, 8'h00, 1'b0);
		queue_request(OP_GET, 4, 8'h00, 1'b0);
		queue_request(OP_GET, 5, 8'h00, 1'b0);
		queue_request(OP_GET, 1, 8'hFF, 1'b0);
		queue_request(OP_LOCATE, 127, 8'hFF, 1'b0);
		queue_request(OP_LOCATE, 3, 8'h55, 1'b0);
		queue_request(OP_INSERT, 5, 8'h7F, 1'b0);
		queue_request(OP_LOCATE, 0, 8'h7F, 1'b0);
		queue_request(OP_DELETE, 5, 8'h00, 1'b0);
		queue_request(OP_DELETE, 1, 8'h00, 1'b0);
		queue_request(OP_DELETE, 0, 8'h00, 1'b0);
		queue_request(OP_DELETE, 127, 8'h00, 1'b0);
		queue_request(OP_GET, 64, 8'h00, 1'b0);
		queue_request(OP_DELETE, 2, 8'h00, 1'b0);
		queue_request(OP_LOCATE, 1, 8'h80, 1'b0);

		// first phase fills the list past full, second drains it
		phase = 0;
		rand_cnt = 0;
		while (rand_cnt < N_RANDOM) begin
			if (phase == 0) begin
				mix = MIX_GROW;
				len = 220;
			end else if (phase == 1) begin
				mix = MIX_SHRINK;
				len = 220;
			end else begin
				mix = mix_t'($urandom_range(0, 2));
				len = $urandom_range(40, 160);
			end
			for (int k = 0; k < len; k++) begin
				w = $urandom_range(0, 99);
				case (mix)
					MIX_GROW:   op = w < 65 ? OP_INSERT : w < 75 ? OP_DELETE :
						w < 88 ? OP_GET : OP_LOCATE;
					MIX_SHRINK: op = w < 15 ? OP_INSERT : w < 70 ? OP_DELETE :
						w < 85 ? OP_GET : OP_LOCATE;
					default:    op = w < 35 ? OP_INSERT : w < 65 ? OP_DELETE :
						w < 82 ? OP_GET : OP_LOCATE;
				endcase
				// hold the first request of each phase until the pipe drains
				queue_request(op, pick_position(op, gen_fill), pick_value(), k == 0);
				rand_cnt++;
			end
			phase++;
		end
		n_stim = pending.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d requests: %0d insert, %0d delete, %0d get, %0d locate.",
			sent_cnt, op_seen[OP_INSERT], op_seen[OP_DELETE], op_seen[OP_GET],
			op_seen[OP_LOCATE]);
		$display("%0d rejected (%0d on a full list), %0d locate hits, peak length %0d, %0d checked.",
			rejects, full_rejects, locate_hits, deepest, checked_cnt);
		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
